// ----- rtl/capacitive_baseline_averager_assert.svh -----
// assertion macros for the capacitive baseline averager
// expects clk and arst_n in the scope of the module that uses them
`ifndef CAPACITIVE_BASELINE_AVERAGER_ASSERT_SVH
`define CAPACITIVE_BASELINE_AVERAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBA_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("cba assertion failed");
`define CBA_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cba assertion failed");
`define CBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cba assertion failed");
`else
`define CBA_ASSERT(lbl, cond)
`define CBA_ASSERT_IMPLY(lbl, ante, cons)
`define CBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/cba_pkg.sv -----
// shared types, constants and helpers of the capacitive baseline averager
// no dependencies
package cba_pkg;

	localparam int NUM_CH      = 8;
	localparam int READING_W   = 28;
	localparam int AVG_W       = 20;
	localparam int TICK_W      = 16;
	localparam int OFFSET_W    = 28;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 28;
	localparam int BASE_W      = 26;
	localparam int DEV_W       = 23;
	localparam int SCALED_W    = 20;

	localparam int CHANNELS_DEF      = 8;
	localparam int CALIB_SAMPLES_DEF = 100;
	localparam int AVG_SAMPLES_DEF   = 10;

	// reading scale: exact reciprocal for any reading magnitude
	localparam int SCALE_DIV = 1000;
	localparam int DIV1000_SHIFT = READING_W + $clog2(SCALE_DIV);
	localparam logic [63:0] DIV1000_RECIP =
		((64'd1 << DIV1000_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);

	localparam logic [TICK_W-1:0]   TICK_DIV_RESET     = 16'd20;
	localparam logic [OFFSET_W-1:0] CALIB_OFFSET_RESET = 28'd22000000;
	localparam logic [OFFSET_W-1:0] MEAS_OFFSET_RESET  = 28'd20000000;

	// cycles the input is held after the last calibration sample
	localparam int BASE_WAIT = 2;
	localparam int WAIT_W    = $clog2(BASE_WAIT + 1);

	localparam logic [CFG_INDEX_W-1:0] CFG_TICK_DIVIDER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MEAS_OFFSET  = 2'd2;

	typedef struct packed {
		logic [READING_W-1:0] reading_ch0;
		logic [READING_W-1:0] reading_ch1;
		logic [READING_W-1:0] reading_ch2;
		logic [READING_W-1:0] reading_ch3;
		logic [READING_W-1:0] reading_ch4;
		logic [READING_W-1:0] reading_ch5;
		logic [READING_W-1:0] reading_ch6;
		logic [READING_W-1:0] reading_ch7;
	} tick_item_t;

	typedef struct packed {
		logic [AVG_W-1:0] avg_ch0;
		logic [AVG_W-1:0] avg_ch1;
		logic [AVG_W-1:0] avg_ch2;
		logic [AVG_W-1:0] avg_ch3;
		logic [AVG_W-1:0] avg_ch4;
		logic [AVG_W-1:0] avg_ch5;
		logic [AVG_W-1:0] avg_ch6;
		logic [AVG_W-1:0] avg_ch7;
	} avg_item_t;

	typedef logic [NUM_CH-1:0][READING_W-1:0] reading_vec_t;
	typedef logic [NUM_CH-1:0][AVG_W-1:0]     avg_vec_t;

	typedef struct packed {
		logic valid;
		logic calib;
		logic calib_last;
		logic emit;
	} seq_flags_t;

	function automatic reading_vec_t unpack_readings(input tick_item_t t);
		reading_vec_t r;
		r[0] = t.reading_ch0;
		r[1] = t.reading_ch1;
		r[2] = t.reading_ch2;
		r[3] = t.reading_ch3;
		r[4] = t.reading_ch4;
		r[5] = t.reading_ch5;
		r[6] = t.reading_ch6;
		r[7] = t.reading_ch7;
		return r;
	endfunction

	function automatic avg_item_t pack_avgs(input avg_vec_t v);
		avg_item_t a;
		a.avg_ch0 = v[0];
		a.avg_ch1 = v[1];
		a.avg_ch2 = v[2];
		a.avg_ch3 = v[3];
		a.avg_ch4 = v[4];
		a.avg_ch5 = v[5];
		a.avg_ch6 = v[6];
		a.avg_ch7 = v[7];
		return a;
	endfunction

endpackage

// ----- rtl/cba_ctrl.sv -----
// sample sequencing, configuration registers and input flow control
// depends on cba_pkg and the assertion macro header
`include "capacitive_baseline_averager_assert.svh"

module cba_ctrl import cba_pkg::*; #(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  logic                   avg_fire,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [OFFSET_W-1:0]    offset,
	output seq_flags_t             acc_flags,
	output seq_flags_t             fin_flags
);

	localparam int CALIB_CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam int AVG_CNT_W   = $clog2(AVG_SAMPLES + 1);

	logic [TICK_W-1:0]      tick_div_q;
	logic [OFFSET_W-1:0]    calib_off_q;
	logic [OFFSET_W-1:0]    meas_off_q;
	logic [TICK_W-1:0]      tick_cnt_q;
	logic                   calibrated_q;
	logic [CALIB_CNT_W-1:0] calib_cnt_q;
	logic [AVG_CNT_W-1:0]   avg_cnt_q;
	logic [WAIT_W-1:0]      wait_q;
	logic                   pending_q;
	seq_flags_t             flags_s1, flags_s2, flags_s3, flags_s4, flags_s5;

	logic [TICK_W:0]        tick_next;
	logic                   is_sample;
	logic [CALIB_CNT_W-1:0] calib_next;
	logic                   calib_done;
	logic [AVG_CNT_W-1:0]   avg_next;
	logic                   avg_done;
	logic                   accept;
	seq_flags_t             f0;
	seq_flags_t             f_in;

	always_comb begin
		tick_next  = {1'b0, tick_cnt_q} + {{TICK_W{1'b0}}, 1'b1};
		is_sample  = !(tick_next < {1'b0, tick_div_q});
		calib_next = calib_cnt_q + {{(CALIB_CNT_W-1){1'b0}}, 1'b1};
		calib_done = calib_next >= CALIB_CNT_W'(CALIB_SAMPLES);
		avg_next   = avg_cnt_q + {{(AVG_CNT_W-1){1'b0}}, 1'b1};
		avg_done   = avg_next >= AVG_CNT_W'(AVG_SAMPLES);
		f0.valid      = is_sample;
		f0.calib      = !calibrated_q;
		f0.calib_last = is_sample && !calibrated_q && calib_done;
		f0.emit       = is_sample && calibrated_q && avg_done;
		tick_stall = (wait_q != '0) || (f0.emit && pending_q);
		accept     = tick_valid && !tick_stall;
		f_in       = accept ? f0 : '0;
	end

	assign cfg_ready = 1'b1;
	assign offset    = calibrated_q ? meas_off_q : calib_off_q;
	assign acc_flags = flags_s3;
	assign fin_flags = flags_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q  <= TICK_DIV_RESET;
			calib_off_q <= CALIB_OFFSET_RESET;
			meas_off_q  <= MEAS_OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICK_DIVIDER: tick_div_q  <= cfg_data[TICK_W-1:0];
				CFG_CALIB_OFFSET: calib_off_q <= cfg_data[OFFSET_W-1:0];
				CFG_MEAS_OFFSET:  meas_off_q  <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q   <= '0;
			calibrated_q <= 1'b0;
			calib_cnt_q  <= '0;
			avg_cnt_q    <= '0;
		end else if (accept) begin
			if (!is_sample) begin
				tick_cnt_q <= tick_next[TICK_W-1:0];
			end else begin
				tick_cnt_q <= '0;
				if (!calibrated_q) begin
					if (calib_done) begin
						calibrated_q <= 1'b1;
						calib_cnt_q  <= '0;
					end else begin
						calib_cnt_q <= calib_next;
					end
				end else if (avg_done) begin
					avg_cnt_q <= '0;
				end else begin
					avg_cnt_q <= avg_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= '0;
			pending_q <= 1'b0;
		end else begin
			priority if (accept && f0.calib_last) begin
				wait_q <= WAIT_W'(BASE_WAIT);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - {{(WAIT_W-1){1'b0}}, 1'b1};
			end
			priority if (accept && f0.emit) begin
				pending_q <= 1'b1;
			end else if (avg_fire) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
			flags_s3 <= '0;
			flags_s4 <= '0;
			flags_s5 <= '0;
		end else begin
			flags_s1 <= f_in;
			flags_s2 <= flags_s1;
			flags_s3 <= flags_s2;
			flags_s4 <= flags_s3;
			flags_s5 <= flags_s4;
		end
	end

	`CBA_ASSERT_NEXT(a_calib_end_holds_input, accept && f0.calib_last, tick_stall)
	`CBA_ASSERT(a_baseline_ready_for_meas, !(flags_s3.valid && !flags_s3.calib && ((flags_s4.valid && flags_s4.calib_last) || (flags_s5.valid && flags_s5.calib_last))))
	`CBA_ASSERT_IMPLY(a_one_result_in_flight, accept && f0.emit, !pending_q)

endmodule

// ----- rtl/cba_lane.sv -----
// one channel: reading scale, baseline and deviation accumulation, averaging
// depends on cba_pkg
module cba_lane import cba_pkg::*; #(
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [READING_W-1:0] reading,
	input  logic [OFFSET_W-1:0]  offset,
	input  seq_flags_t           acc_flags,
	input  seq_flags_t           fin_flags,
	output logic [AVG_W-1:0]     avg
);

	localparam int DIFF_W      = READING_W + 1;
	localparam int QUOT_W      = SCALED_W - 1;
	localparam int SPROD_W     = DIV1000_SHIFT + QUOT_W;
	localparam int DEV_DIFF_W  = BASE_W + 1;
	localparam int CALIB_SHIFT = BASE_W + $clog2(CALIB_SAMPLES);
	localparam logic [63:0] CALIB_RECIP =
		((64'd1 << CALIB_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
	localparam int BPROD_W     = CALIB_SHIFT + BASE_W;
	localparam int AVG_SHIFT   = DEV_W + $clog2(AVG_SAMPLES);
	localparam logic [63:0] AVG_RECIP =
		((64'd1 << AVG_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
	localparam int DPROD_W     = AVG_SHIFT + AVG_W;

	logic [DIFF_W-1:0]     diff;
	logic [DIFF_W-1:0]     diff_abs;
	logic                  neg_s1, neg_s2;
	logic [READING_W-1:0]  mag_s1;
	logic [SPROD_W-1:0]    prod_s2;
	logic [QUOT_W-1:0]     quot;
	logic [SCALED_W-1:0]   scaled_s3;

	logic [BASE_W-1:0]     base_q;
	logic [DEV_W-1:0]      dev_q;
	logic [BASE_W-1:0]     sum_new;
	logic [BASE_W-1:0]     sum_abs;
	logic [DEV_DIFF_W-1:0] dev_diff;
	logic [DEV_DIFF_W-1:0] dev_abs;
	logic [DEV_W-1:0]      dev_new;

	logic                  bneg_s4, bneg_s5;
	logic [BASE_W-1:0]     babs_s4;
	logic [BPROD_W-1:0]    bprod_s5;
	logic [BASE_W-1:0]     bquot;
	logic [BASE_W-1:0]     baseline;
	logic [DEV_W-1:0]      dsum_s4;
	logic [DPROD_W-1:0]    dprod_s5;

	always_comb begin
		diff     = {1'b0, reading} - {1'b0, offset};
		diff_abs = diff[DIFF_W-1] ? -diff : diff;
		quot     = prod_s2[DIV1000_SHIFT +: QUOT_W];
	end

	always_ff @(posedge clk) begin
		neg_s1    <= diff[DIFF_W-1];
		mag_s1    <= diff_abs[READING_W-1:0];
		neg_s2    <= neg_s1;
		prod_s2   <= SPROD_W'(mag_s1) * SPROD_W'(DIV1000_RECIP);
		scaled_s3 <= neg_s2 ? -{1'b0, quot} : {1'b0, quot};
	end

	always_comb begin
		sum_new  = base_q + {{(BASE_W-SCALED_W){scaled_s3[SCALED_W-1]}}, scaled_s3};
		sum_abs  = sum_new[BASE_W-1] ? -sum_new : sum_new;
		dev_diff = {{(DEV_DIFF_W-SCALED_W){scaled_s3[SCALED_W-1]}}, scaled_s3}
			- {base_q[BASE_W-1], base_q};
		dev_abs  = dev_diff[DEV_DIFF_W-1] ? -dev_diff : dev_diff;
		dev_new  = dev_q + dev_abs[DEV_W-1:0];
		bquot    = bprod_s5[CALIB_SHIFT +: BASE_W];
		baseline = bneg_s5 ? -bquot : bquot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			dev_q  <= '0;
		end else begin
			priority if (fin_flags.valid && fin_flags.calib_last) begin
				base_q <= baseline;
			end else if (acc_flags.valid && acc_flags.calib) begin
				base_q <= sum_new;
			end
			if (acc_flags.valid && !acc_flags.calib) begin
				dev_q <= acc_flags.emit ? '0 : dev_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		bneg_s4  <= sum_new[BASE_W-1];
		babs_s4  <= sum_abs;
		bneg_s5  <= bneg_s4;
		bprod_s5 <= BPROD_W'(babs_s4) * BPROD_W'(CALIB_RECIP);
		dsum_s4  <= dev_new;
		dprod_s5 <= DPROD_W'(dsum_s4) * DPROD_W'(AVG_RECIP);
	end

	assign avg = dprod_s5[AVG_SHIFT +: AVG_W];

endmodule

// ----- rtl/cba_merge.sv -----
// gathers the lane averages into one result and holds it for the output side
// depends on cba_pkg and the assertion macro header
`include "capacitive_baseline_averager_assert.svh"

module cba_merge import cba_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [CHANNELS-1:0][AVG_W-1:0]  lane_avg,
	input  logic                            emit,
	output logic                            avg_valid,
	input  logic                            avg_stall,
	output avg_item_t                       avg_data
);

	avg_vec_t  avg_vec;
	logic      valid_q;
	avg_item_t data_q;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		if (i < CHANNELS) begin : g_used
			assign avg_vec[i] = lane_avg[i];
		end else begin : g_unused
			assign avg_vec[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= pack_avgs(avg_vec);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!avg_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign avg_valid = valid_q;
	assign avg_data  = data_q;

	`CBA_ASSERT_IMPLY(a_no_result_overwrite, emit, !valid_q)

endmodule

// ----- rtl/capacitive_baseline_averager.sv -----
// a tick that closes an averaging block shows its result through flag stages s1 to s5 and the registered merge output
// throughput: one tick per cycle through the CHANNELS channel lanes, except while tick_stall is high
// input is held after the last calibration sample while the baseline divide runs
// a tick that closes a block waits while the previous result is not yet taken
// reset: counters, sums and flags clear, registers return to defaults, no clearing pass
module capacitive_baseline_averager import cba_pkg::*; #(
	parameter int CHANNELS      = CHANNELS_DEF,
	parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
	parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  tick_item_t             tick_data,
	output logic                   avg_valid,
	input  logic                   avg_stall,
	output avg_item_t              avg_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	reading_vec_t                   readings;
	logic [OFFSET_W-1:0]            offset;
	seq_flags_t                     acc_flags;
	seq_flags_t                     fin_flags;
	logic [CHANNELS-1:0][AVG_W-1:0] lane_avg;
	logic                           avg_fire;

	assign readings = unpack_readings(tick_data);
	assign avg_fire = avg_valid && !avg_stall;

	cba_ctrl #(
		.CALIB_SAMPLES(CALIB_SAMPLES),
		.AVG_SAMPLES  (AVG_SAMPLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.avg_fire  (avg_fire),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.offset    (offset),
		.acc_flags (acc_flags),
		.fin_flags (fin_flags)
	);

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		cba_lane #(
			.CALIB_SAMPLES(CALIB_SAMPLES),
			.AVG_SAMPLES  (AVG_SAMPLES)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.reading  (readings[i]),
			.offset   (offset),
			.acc_flags(acc_flags),
			.fin_flags(fin_flags),
			.avg      (lane_avg[i])
		);
	end

	cba_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.lane_avg (lane_avg),
		.emit     (fin_flags.valid && fin_flags.emit),
		.avg_valid(avg_valid),
		.avg_stall(avg_stall),
		.avg_data (avg_data)
	);

endmodule
